>>> design/dtep_pkg.sv
package dtep_pkg;

  // datapath word and fixed-point formats
  localparam int DATA_W       = 64;
  localparam int RAD_BITS     = 60;
  localparam int TURN_BITS    = 48;
  localparam int CORDIC_STEPS = 50;

  // configuration registers
  localparam int SIZE_REG_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam logic [SIZE_REG_W-1:0] WIDTH_RST  = SIZE_REG_W'(1024);
  localparam logic [SIZE_REG_W-1:0] HEIGHT_RST = SIZE_REG_W'(512);

  // default parameter values
  localparam int COMPONENT_BITS_DEF  = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 20;
  localparam int SIZE_BITS_DEF       = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // one shift-add vectoring pair plus its angle accumulator
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] ang;
  } vec_t;

  // front stage result for both first-phase lanes
  typedef struct packed {
    vec_t yaw;
    vec_t gain;
    logic nz;
    logic yneg;
  } front_t;

  // advance strobes of the back end
  typedef struct packed {
    logic pipe;
    logic out;
  } adv_t;

  typedef logic [CORDIC_STEPS-1:0][TURN_BITS-1:0] angle_tab_t;

  localparam logic [DATA_W-1:0] RAD_ONE = DATA_W'(1) << RAD_BITS;

  // restoring divide, elaboration only
  function automatic logic [DATA_W-1:0] udiv64(input logic [DATA_W-1:0] num,
                                               input logic [DATA_W-1:0] den);
    logic [DATA_W:0]   rem;
    logic [DATA_W-1:0] quo;
    rem = '0;
    quo = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      rem = {rem[DATA_W-1:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // arctan(1/n) in radians, 60 fractional bits, truncated series
  function automatic logic [DATA_W-1:0] series_recip(input logic [DATA_W-1:0] n);
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] nn;
    logic              neg;
    p   = udiv64(RAD_ONE, n);
    sum = '0;
    neg = 1'b0;
    nn  = n * n;
    for (int k = 0; k < DATA_W; k++) begin
      if (p != '0) begin
        t   = udiv64(p, DATA_W'(2 * k + 1));
        sum = neg ? sum - t : sum + t;
        p   = udiv64(p, nn);
        neg = !neg;
      end
    end
    return sum;
  endfunction

  // arctan(2^-i) in radians, 60 fractional bits, truncated series
  function automatic logic [DATA_W-1:0] series_pow2(input int i);
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] t;
    logic              neg;
    p   = RAD_ONE >> i;
    sum = '0;
    neg = 1'b0;
    for (int k = 0; k < DATA_W; k++) begin
      if (p != '0) begin
        t   = udiv64(p, DATA_W'(2 * k + 1));
        sum = neg ? sum - t : sum + t;
        p   = (2 * i < DATA_W) ? (p >> (2 * i)) : '0;
        neg = !neg;
      end
    end
    return sum;
  endfunction

  // per-step angle in turns, rounded to nearest at TURN_BITS
  function automatic angle_tab_t build_angle_tab();
    angle_tab_t        tab;
    logic [DATA_W-1:0] qpi;
    logic [DATA_W-1:0] two_pi;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] q;
    qpi    = (series_recip(DATA_W'(5)) << 2) - series_recip(DATA_W'(239));
    two_pi = qpi << 3;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      r = (i == 0) ? qpi : series_pow2(i);
      q = '0;
      for (int j = 0; j <= TURN_BITS; j++) begin
        r = r << 1;
        q = q << 1;
        if (r >= two_pi) begin
          r    = r - two_pi;
          q[0] = 1'b1;
        end
      end
      tab[i] = TURN_BITS'((q + DATA_W'(1)) >> 1);
    end
    return tab;
  endfunction

  localparam angle_tab_t ANGLE_TAB = build_angle_tab();

endpackage

>>> design/dtep_front.sv
module dtep_front import dtep_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [COMPONENT_BITS-1:0] dir_x_i,
  input  logic [COMPONENT_BITS-1:0] dir_y_i,
  input  logic [COMPONENT_BITS-1:0] dir_z_i,
  output logic                      vld_o,
  output front_t                    front_o
);

  localparam int SCALE_SH = RAD_BITS - COMPONENT_BITS;
  localparam int EXT_W    = DATA_W - COMPONENT_BITS;
  localparam logic signed [DATA_W-1:0] HALF_TURN = DATA_W'(1) << (TURN_BITS - 1);

  logic signed [DATA_W-1:0] xs, ys, zs;
  front_t front_d, front_q;
  logic   vld_q;

  // scale components up to the 60 fractional bit format
  assign xs = {{EXT_W{dir_x_i[COMPONENT_BITS-1]}}, dir_x_i} <<< SCALE_SH;
  assign ys = {{EXT_W{dir_y_i[COMPONENT_BITS-1]}}, dir_y_i} <<< SCALE_SH;
  assign zs = {{EXT_W{dir_z_i[COMPONENT_BITS-1]}}, dir_z_i} <<< SCALE_SH;

  // fold the rear half plane forward and seed the angle with plus or minus half a turn
  always_comb begin
    front_d.nz   = (dir_x_i != '0) || (dir_z_i != '0);
    front_d.yneg = dir_y_i[COMPONENT_BITS-1];
    if (zs[DATA_W-1]) begin
      front_d.yaw.a   = -zs;
      front_d.yaw.b   = -xs;
      front_d.yaw.ang = xs[DATA_W-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      front_d.yaw.a   = zs;
      front_d.yaw.b   = xs;
      front_d.yaw.ang = '0;
    end
    // gain lane: |y| through the same steps so both magnitudes match
    front_d.gain.a   = ys[DATA_W-1] ? -ys : ys;
    front_d.gain.b   = '0;
    front_d.gain.ang = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign vld_o   = vld_q;
  assign front_o = front_q;

endmodule

>>> design/dtep_vector.sv
module dtep_vector import dtep_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  vec_t              vec_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output vec_t              vec_o,
  output logic [SIDE_W-1:0] side_o
);

  vec_t              vec_w  [CORDIC_STEPS+1];
  logic              vld_w  [CORDIC_STEPS+1];
  logic [SIDE_W-1:0] side_w [CORDIC_STEPS+1];

  assign vec_w[0]  = vec_i;
  assign vld_w[0]  = vld_i;
  assign side_w[0] = side_i;

  // one registered shift-add step per stage
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
    localparam logic signed [DATA_W-1:0] ANG_STEP = DATA_W'(ANGLE_TAB[s]);

    vec_t              cur;
    vec_t              vec_d, vec_q;
    logic              vld_q;
    logic [SIDE_W-1:0] side_q;

    assign cur = vec_w[s];

    // rotate toward b = 0, shifts floor toward minus infinity
    always_comb begin
      if (!cur.b[DATA_W-1]) begin
        vec_d.a   = cur.a + ($signed(cur.b) >>> s);
        vec_d.b   = cur.b - ($signed(cur.a) >>> s);
        vec_d.ang = cur.ang + ANG_STEP;
      end else begin
        vec_d.a   = cur.a - ($signed(cur.b) >>> s);
        vec_d.b   = cur.b + ($signed(cur.a) >>> s);
        vec_d.ang = cur.ang - ANG_STEP;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vec_q  <= vec_d;
        side_q <= side_w[s];
      end
    end

    assign vec_w[s+1]  = vec_q;
    assign vld_w[s+1]  = vld_q;
    assign side_w[s+1] = side_q;
  end

  assign vld_o  = vld_w[CORDIC_STEPS];
  assign vec_o  = vec_w[CORDIC_STEPS];
  assign side_o = side_w[CORDIC_STEPS];

endmodule

>>> design/dtep_pixel.sv
module dtep_pixel import dtep_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int SIZE_BITS       = SIZE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  adv_t                     adv_i,
  input  logic                     vld_i,
  input  logic signed [DATA_W-1:0] yaw_i,
  input  logic signed [DATA_W-1:0] pitch_i,
  input  logic                     pz_i,
  input  logic [SIZE_REG_W-1:0]    size_w_i,
  input  logic [SIZE_REG_W-1:0]    size_h_i,
  output logic                     pre_vld_o,
  output logic                     vld_o,
  output logic [SIZE_BITS-1:0]     pixel_x_o,
  output logic [SIZE_BITS-1:0]     pixel_y_o
);

  localparam int SH     = TURN_BITS - ANGLE_FRAC_BITS;
  localparam int RND_W  = DATA_W - SH;
  localparam int FRAC_W = ANGLE_FRAC_BITS + 1;
  localparam int PROD_W = SIZE_REG_W + FRAC_W;

  localparam logic signed [DATA_W-1:0] HALF_TURN = DATA_W'(1) << (TURN_BITS - 1);
  localparam logic signed [DATA_W-1:0] QUARTER   = DATA_W'(1) << (TURN_BITS - 2);
  localparam logic signed [DATA_W-1:0] HALF_ULP  = DATA_W'(1) << (SH - 1);
  localparam logic signed [DATA_W-1:0] U_BIAS    = HALF_TURN + HALF_ULP;
  localparam logic signed [DATA_W-1:0] P_BIAS    = QUARTER + HALF_ULP;
  localparam logic [FRAC_W-1:0]        FULL      = FRAC_W'(1) << ANGLE_FRAC_BITS;
  localparam logic [SIZE_REG_W-1:0]    LIM       =
    SIZE_REG_W'((DATA_W'(1) << SIZE_BITS) - DATA_W'(1));

  // stage 1: bias and round-up add, clamp flags
  logic signed [DATA_W-1:0] pitch_eff;
  logic [DATA_W-1:0] ut_d, ut_q, pt_d, pt_q;
  logic              uneg_d, uneg_q, pneg_d, pneg_q;
  logic              s1_vld_q;

  assign pitch_eff = pz_i ? '0 : pitch_i;
  assign ut_d      = yaw_i + U_BIAS;
  assign uneg_d    = yaw_i < -HALF_TURN;
  assign pt_d      = pitch_eff + P_BIAS;
  assign pneg_d    = pitch_eff < -QUARTER;

  // stage 2: drop to the angle format and clamp to one full turn
  logic [RND_W-1:0]  ur;
  logic [RND_W:0]    vr;
  logic [FRAC_W-1:0] fu_d, fu_q, fv_d, fv_q;
  logic              s2_vld_q;

  always_comb begin
    ur = uneg_q ? '0 : ut_q[DATA_W-1:SH];
    vr = pneg_q ? '0 : {pt_q[DATA_W-1:SH], 1'b0};
    fu_d = (ur > RND_W'(FULL)) ? FULL : ur[FRAC_W-1:0];
    fv_d = (vr > (RND_W + 1)'(FULL)) ? FULL : vr[FRAC_W-1:0];
  end

  // stage 3: scale by the map size
  logic [PROD_W-1:0] prod_x_d, prod_x_q, prod_y_d, prod_y_q;
  logic              s3_vld_q;

  assign prod_x_d = PROD_W'(size_w_i) * PROD_W'(fu_q);
  assign prod_y_d = PROD_W'(size_h_i) * PROD_W'(fv_q);

  // stage 4: floor and clamp into the map
  function automatic logic [SIZE_BITS-1:0] clamp_pix(input logic [SIZE_REG_W-1:0] size,
                                                     input logic [SIZE_REG_W:0]   p);
    logic [SIZE_REG_W-1:0] c;
    if (p >= {1'b0, size}) begin
      c = size - SIZE_REG_W'(1);
    end else begin
      c = p[SIZE_REG_W-1:0];
    end
    if (size == '0) begin
      c = '0;
    end
    if (c > LIM) begin
      c = LIM;
    end
    return SIZE_BITS'(c);
  endfunction

  logic [SIZE_BITS-1:0] px_d, px_q, py_d, py_q;
  logic                 out_vld_q;

  assign px_d = clamp_pix(size_w_i, prod_x_q[ANGLE_FRAC_BITS +: SIZE_REG_W + 1]);
  assign py_d = clamp_pix(size_h_i, prod_y_q[ANGLE_FRAC_BITS +: SIZE_REG_W + 1]);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_i.pipe) begin
        s1_vld_q <= vld_i;
        s2_vld_q <= s1_vld_q;
        s3_vld_q <= s2_vld_q;
      end
      if (adv_i.out) begin
        out_vld_q <= s3_vld_q;
      end
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    if (adv_i.pipe) begin
      ut_q     <= ut_d;
      uneg_q   <= uneg_d;
      pt_q     <= pt_d;
      pneg_q   <= pneg_d;
      fu_q     <= fu_d;
      fv_q     <= fv_d;
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
    if (adv_i.out) begin
      px_q <= px_d;
      py_q <= py_d;
    end
  end

  assign pre_vld_o = s3_vld_q;
  assign vld_o     = out_vld_q;
  assign pixel_x_o = px_q;
  assign pixel_y_o = py_q;

`ifndef SYNTH
  a_fu_in_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> fu_q <= FULL)
    else $error("column fraction above one turn");

  a_fv_in_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> fv_q <= FULL)
    else $error("row fraction above one turn");

  a_fv_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> !fv_q[0])
    else $error("row fraction lost its doubling");
`endif

endmodule

>>> design/direction_to_equirect_pixel_top.sv
// Maps a direction (dir_x, dir_y, dir_z: two's complement, any common scale,
// y up, z forward) to the equirectangular map pixel it hits: the column comes
// from yaw = atan2(x, z) and the row from pitch = atan2(y, |xz|), both found by
// 50-step shift-add vectoring and rounded to ANGLE_FRAC_BITS fractional bits of
// a turn, then scaled by image_width / image_height and clamped to size - 1.
// A zero vector lands on the centre pixel, a zero size gives pixel 0. The
// datapath is a 106-stage pipeline (one input stage, 50 yaw and gain steps side
// by side, one join stage, 50 pitch steps, four rounding, scaling and clamp
// stages) that takes one word per clock unless a held output freezes it. A held
// output freezes the pipeline only once the stage behind it is full. Size
// registers are written through cfg_we_i / cfg_idx_i (0 width, 1 height) and
// should only change while no word is in flight.
module direction_to_equirect_pixel_top import dtep_pkg::*; #(
  parameter int COMPONENT_BITS  = COMPONENT_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int SIZE_BITS       = SIZE_BITS_DEF,
  localparam int IN_W           = ((3 * COMPONENT_BITS + 7) / 8) * 8,
  localparam int OUT_W          = ((2 * SIZE_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,   // dir_x, dir_y, dir_z
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // pixel_x, pixel_y
  // register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [SIZE_REG_W-1:0] cfg_wdata_i
);

  localparam int CB = COMPONENT_BITS;

  // size registers
  logic [SIZE_REG_W-1:0] size_w_q, size_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_w_q <= WIDTH_RST;
      size_h_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  size_w_q <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: size_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stall control: everything behind the output register moves unless it is
  // held and the stage right behind it is full
  adv_t adv;
  logic pre_vld;
  logic out_vld;

  assign adv.out       = !out_vld || m_axis_tready;
  assign adv.pipe      = adv.out || !pre_vld;
  assign s_axis_tready = adv.pipe;

  // input stage
  logic   fr_vld;
  front_t fr;

  dtep_front #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv.pipe),
    .vld_i  (s_axis_tvalid),
    .dir_x_i(s_axis_tdata[CB-1:0]),
    .dir_y_i(s_axis_tdata[2*CB-1:CB]),
    .dir_z_i(s_axis_tdata[3*CB-1:2*CB]),
    .vld_o  (fr_vld),
    .front_o(fr)
  );

  // first phase: yaw lane and gain lane in lockstep
  logic yaw_vld, gain_vld;
  vec_t yaw_v, gain_v;
  logic yaw_nz, gain_yneg;

  dtep_vector #(
    .SIDE_W(1)
  ) u_yaw (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv.pipe),
    .vld_i (fr_vld),
    .vec_i (fr.yaw),
    .side_i(fr.nz),
    .vld_o (yaw_vld),
    .vec_o (yaw_v),
    .side_o(yaw_nz)
  );

  dtep_vector #(
    .SIDE_W(1)
  ) u_gain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv.pipe),
    .vld_i (fr_vld),
    .vec_i (fr.gain),
    .side_i(fr.yneg),
    .vld_o (gain_vld),
    .vec_o (gain_v),
    .side_o(gain_yneg)
  );

  // join stage: horizontal length and signed vertical part for pitch
  vec_t                     mid_d, mid_q;
  logic signed [DATA_W-1:0] yaw_ang_d, yaw_ang_q;
  logic                     pz_d, pz_q;
  logic                     mid_vld_q;

  always_comb begin
    mid_d.a   = yaw_nz ? yaw_v.a : '0;
    mid_d.b   = gain_yneg ? -gain_v.a : gain_v.a;
    mid_d.ang = '0;
    yaw_ang_d = yaw_nz ? yaw_v.ang : '0;
    pz_d      = (mid_d.a == '0) && (mid_d.b == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
    end else if (adv.pipe) begin
      mid_vld_q <= yaw_vld && gain_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv.pipe) begin
      mid_q     <= mid_d;
      yaw_ang_q <= yaw_ang_d;
      pz_q      <= pz_d;
    end
  end

  // second phase: pitch, carrying yaw and the zero flag alongside
  logic                     pit_vld;
  vec_t                     pit_v;
  logic [DATA_W:0]          pit_side;

  dtep_vector #(
    .SIDE_W(DATA_W + 1)
  ) u_pitch (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv.pipe),
    .vld_i (mid_vld_q),
    .vec_i (mid_q),
    .side_i({pz_q, yaw_ang_q}),
    .vld_o (pit_vld),
    .vec_o (pit_v),
    .side_o(pit_side)
  );

  // rounding, scaling, clamp and output register
  logic [SIZE_BITS-1:0] pixel_x, pixel_y;

  dtep_pixel #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_pixel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .vld_i    (pit_vld),
    .yaw_i    (pit_side[DATA_W-1:0]),
    .pitch_i  (pit_v.ang),
    .pz_i     (pit_side[DATA_W]),
    .size_w_i (size_w_q),
    .size_h_i (size_h_q),
    .pre_vld_o(pre_vld),
    .vld_o    (out_vld),
    .pixel_x_o(pixel_x),
    .pixel_y_o(pixel_y)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = OUT_W'({pixel_y, pixel_x});

`ifndef SYNTH
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yaw_vld == gain_vld)
    else $error("yaw and gain lanes out of step");

  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output side is ready");

  a_block_means_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> m_axis_tvalid)
    else $error("input blocked without a held output word");
`endif

endmodule

>>> verif/tb_direction_to_equirect_pixel_top.sv
module tb_direction_to_equirect_pixel_top import dtep_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // fixed-point formats of the angle path
  localparam int STEPS      = 50;
  localparam int TURN_FRAC  = 48;
  localparam int ANGLE_FRAC = 20;
  localparam int COMP_SHIFT = 60 - 16;
  localparam int ROUND_SH   = TURN_FRAC - ANGLE_FRAC;
  localparam int RAND_ITEMS = 102;
  localparam int N_PHASES   = 9;

  typedef logic signed [63:0] s64_t;

  localparam logic [63:0] RAD_UNIT     = 64'd1 << 60;
  localparam s64_t        HALF_TURN    = s64_t'(1) <<< (TURN_FRAC - 1);
  localparam s64_t        QUARTER_TURN = s64_t'(1) <<< (TURN_FRAC - 2);
  localparam s64_t        HALF_ULP     = s64_t'(1) <<< (ROUND_SH - 1);
  localparam logic [63:0] FULL_FRAC    = 64'd1 << ANGLE_FRAC;

  // one direction word, z x y packed as z:y:x from the top down
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } dir_t;

  typedef struct packed {
    logic [11:0] py;
    logic [11:0] px;
  } pix_t;

  typedef struct packed {
    s64_t mag;
    s64_t ang;
  } vec_res_t;

  localparam logic [15:0] CORNER_VALS [5] = '{16'h8000, 16'hffff, 16'h0000, 16'h0001, 16'h7fff};

  // directed probes, each written as {z, y, x}
  localparam int N_PROBES = 20;
  localparam dir_t PROBES [N_PROBES] = '{
    {16'sd0,      16'sd0,      16'sd0},
    {16'sd32767,  16'sd0,      16'sd0},
    {-16'sd32768, 16'sd0,      16'sd0},
    {16'sd0,      16'sd0,      16'sd32767},
    {16'sd0,      16'sd0,      -16'sd32768},
    {16'sd0,      16'sd32767,  16'sd0},
    {16'sd0,      -16'sd32768, 16'sd0},
    {16'sd32767,  16'sd32767,  16'sd32767},
    {-16'sd32768, -16'sd32768, -16'sd32768},
    {-16'sd32768, 16'sd0,      16'sd1},
    {-16'sd32768, 16'sd0,      -16'sd1},
    {-16'sd1,     16'sd5,      16'sd0},
    {16'sd1,      16'sd1,      16'sd1},
    {-16'sd1,     -16'sd1,     -16'sd1},
    {-16'sd32768, -16'sd32768, 16'sd32767},
    {16'sd32767,  16'sd32767,  -16'sd32768},
    {16'sd0,      16'sd1,      16'sd0},
    {-16'sd1,     16'sd0,      16'sd0},
    {16'sd32767,  16'sd0,      -16'sd32768},
    {-16'sd30000, -16'sd2000,  16'sd12345}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata = '0;   // dir_x, dir_y, dir_z
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;        // pixel_x, pixel_y
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_IMAGE_WIDTH;
  logic [SIZE_REG_W-1:0] cfg_wdata_i = '0;

  // predictor state: size registers as last written, and the per-step angles
  logic [12:0] map_w = 13'd1024;
  logic [12:0] map_h = 13'd512;
  logic [63:0] turn_step [STEPS];

  dir_t pend_dir_q [$];
  pix_t pix_expect_q [$];

  int err_cnt = 0;
  int words_sent = 0;
  int pix_checked = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  direction_to_equirect_pixel_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // arctan series in radians, 60 fractional bits, truncated terms
  function automatic logic [63:0] atan_series(input logic [63:0] first,
                                              input logic [63:0] ratio);
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] k;
    logic        neg;
    p   = first;
    acc = '0;
    k   = '0;
    neg = 1'b0;
    while (p != 0) begin
      if (neg) acc = acc - p / (2 * k + 1);
      else acc = acc + p / (2 * k + 1);
      p   = (ratio == 0) ? 64'd0 : p / ratio;
      k   = k + 1;
      neg = !neg;
    end
    return acc;
  endfunction

  // shift-add vectoring of (a, b) onto the positive a axis
  function automatic vec_res_t vector_to_axis(input s64_t a0, input s64_t b0);
    s64_t     a;
    s64_t     b;
    s64_t     da;
    s64_t     db;
    vec_res_t r;
    a     = a0;
    b     = b0;
    r.ang = '0;
    for (int i = 0; i < STEPS; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a     = a + da;
        b     = b - db;
        r.ang = r.ang + $signed(turn_step[i]);
      end else begin
        a     = a - da;
        b     = b + db;
        r.ang = r.ang - $signed(turn_step[i]);
      end
    end
    r.mag = a;
    return r;
  endfunction

  function automatic s64_t scale_comp(input logic signed [15:0] c);
    return s64_t'({{48{c[15]}}, c}) <<< COMP_SHIFT;
  endfunction

  // fraction of a turn times map size, clamped into the map
  function automatic logic [11:0] scale_to_size(input logic [12:0] size, input s64_t frac);
    logic [63:0] f;
    logic [63:0] p;
    if (size == '0) return '0;
    f = (frac < 0) ? 64'd0 : 64'(frac);
    if (f > FULL_FRAC) f = FULL_FRAC;
    p = (64'(size) * f) >> ANGLE_FRAC;
    if (p >= 64'(size)) p = 64'(size) - 64'd1;
    return (p > 64'd4095) ? 12'hfff : p[11:0];
  endfunction

  function automatic pix_t predict_pixel(input dir_t d);
    s64_t     x;
    s64_t     y;
    s64_t     z;
    s64_t     yaw;
    s64_t     pitch;
    s64_t     horiz;
    s64_t     ky;
    s64_t     u;
    s64_t     pr;
    s64_t     v;
    vec_res_t r;
    pix_t     res;
    x     = scale_comp(d.x);
    y     = scale_comp(d.y);
    z     = scale_comp(d.z);
    yaw   = '0;
    pitch = '0;
    horiz = '0;
    ky    = '0;
    // yaw, with the back half folded forward first
    if (x != 0 || z != 0) begin
      if (z < 0) begin
        r   = vector_to_axis(-z, -x);
        yaw = ((x >= 0) ? HALF_TURN : -HALF_TURN) + r.ang;
      end else begin
        r   = vector_to_axis(z, x);
        yaw = r.ang;
      end
      horiz = r.mag;
    end
    // y gets the same cordic gain as the horizontal length
    if (y != 0) begin
      r  = vector_to_axis((y < 0) ? -y : y, '0);
      ky = (y < 0) ? -r.mag : r.mag;
    end
    if (horiz != 0 || ky != 0) begin
      r     = vector_to_axis(horiz, ky);
      pitch = r.ang;
    end
    // round to the output angle format
    u = yaw + HALF_TURN;
    if (u < 0) u = '0;
    u  = (u + HALF_ULP) >> ROUND_SH;
    pr = pitch + QUARTER_TURN;
    if (pr < 0) pr = '0;
    pr = ((pr + HALF_ULP) >> ROUND_SH) - (QUARTER_TURN >> ROUND_SH);
    v  = (pr <<< 1) + (s64_t'(1) <<< (ANGLE_FRAC - 1));
    res.px = scale_to_size(map_w, u);
    res.py = scale_to_size(map_h, v);
    return res;
  endfunction

  function automatic dir_t random_dir();
    dir_t d;
    int   kind;
    kind = $urandom_range(0, 9);
    d.x  = 16'($urandom);
    d.y  = 16'($urandom);
    d.z  = 16'($urandom);
    case (kind)
      4: begin
        d.x = 16'($urandom_range(0, 64) - 32);
        d.y = 16'($urandom_range(0, 64) - 32);
        d.z = 16'($urandom_range(0, 64) - 32);
      end
      5: begin
        if ($urandom_range(0, 1)) d.x = '0;
        if ($urandom_range(0, 1)) d.y = '0;
        if ($urandom_range(0, 1)) d.z = '0;
      end
      // near the seam straight behind
      6: begin
        d.x = 16'($urandom_range(0, 16) - 8);
        d.z = 16'(0 - $urandom_range(1, 32768));
      end
      // near a pole
      7: begin
        d.x = 16'($urandom_range(0, 16) - 8);
        d.z = 16'($urandom_range(0, 16) - 8);
      end
      8: begin
        d.x = CORNER_VALS[$urandom_range(0, 4)];
        d.y = CORNER_VALS[$urandom_range(0, 4)];
        d.z = CORNER_VALS[$urandom_range(0, 4)];
      end
      default: ;
    endcase
    return d;
  endfunction

  // sender: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (pend_dir_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pend_dir_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches at random between four modes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode       <= 0;
      rx_mode_left  <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(20, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  // monitor: predict on each accepted direction, check each pixel word
  always @(posedge clk_i) begin
    pix_t want;
    pix_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pix_expect_q.insert(pix_expect_q.size(), predict_pixel(dir_t'(s_axis_tdata)));
        words_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = pix_t'(m_axis_tdata);
        if (pix_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected pixel word, got x=%0d y=%0d", $time, got.px, got.py);
        end else begin
          want = pix_expect_q.pop_front();
          pix_checked++;
          if (got.px !== want.px) begin
            err_cnt++;
            $display("%0t: pixel_x mismatch, expected %0d, got %0d", $time, want.px, got.px);
          end
          if (got.py !== want.py) begin
            err_cnt++;
            $display("%0t: pixel_y mismatch, expected %0d, got %0d", $time, want.py, got.py);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pend_dir_q.size() != 0 || s_axis_tvalid || pix_expect_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_size(input cfg_reg_e idx, input logic [12:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_IMAGE_WIDTH) map_w = val;
    else map_h = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // sizes per phase; the last three are random
  localparam logic [12:0] PH_W [N_PHASES] = '{1024, 4096, 1, 0, 4097, 8191, 0, 0, 0};
  localparam logic [12:0] PH_H [N_PHASES] = '{512, 4096, 1, 8191, 0, 4096, 0, 0, 0};

  initial begin : main_seq
    logic [63:0] qpi;
    logic [63:0] two_pi;
    logic [63:0] r;
    logic [63:0] q;
    // per-step angle table in turns
    qpi    = (atan_series(RAD_UNIT / 5, 64'd25) << 2) - atan_series(RAD_UNIT / 239, 64'd57121);
    two_pi = qpi << 3;
    for (int i = 0; i < STEPS; i++) begin
      r = (i == 0) ? qpi
                   : atan_series(RAD_UNIT >> i, (2 * i < 64) ? (64'd1 << (2 * i)) : 64'd0);
      q = '0;
      for (int j = 0; j <= TURN_FRAC; j++) begin
        r = r << 1;
        q = q << 1;
        if (r >= two_pi) begin
          r    = r - two_pi;
          q[0] = 1'b1;
        end
      end
      turn_step[i] = (q + 64'd1) >> 1;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first phase runs on the reset sizes
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        write_size(REG_IMAGE_WIDTH, (ph >= 6) ? 13'($urandom_range(1, 4096)) : PH_W[ph]);
        write_size(REG_IMAGE_HEIGHT, (ph >= 6) ? 13'($urandom_range(1, 4096)) : PH_H[ph]);
      end
      for (int i = 0; i < N_PROBES; i++) pend_dir_q.insert(pend_dir_q.size(), PROBES[i]);
      for (int i = 0; i < RAND_ITEMS / 2; i++)
        pend_dir_q.insert(pend_dir_q.size(), random_dir());
      // hold the sender until the pipeline has emptied
      wait_drained();
      for (int i = RAND_ITEMS / 2; i < RAND_ITEMS; i++)
        pend_dir_q.insert(pend_dir_q.size(), random_dir());
      wait_drained();
    end

    repeat (150) @(posedge clk_i);
    if (pix_expect_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d pixel words never arrived", $time, pix_expect_q.size());
    end
    $display("checked %0d of %0d directions over %0d map sizes", pix_checked, words_sent,
             N_PHASES);
    $display("sizes included zero, one, 4096 and oversize, with stalls on both sides");
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
